// ===== src/accelerometer_tilt_angles_defines.svh =====
// Assertion macros used by the checked module acctilt_fifo.
`ifndef ACCELEROMETER_TILT_ANGLES_DEFINES_SVH
`define ACCELEROMETER_TILT_ANGLES_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define ACT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");
`define ACT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ACT_ASSERT(lbl, prop)
`define ACT_NEVER(lbl, cond)
`endif

`endif

// ===== src/acctilt_pkg.sv =====
`timescale 1ns / 1ps
package acctilt_pkg;

	localparam int ANGLE_FRAC_BITS = 8;
	localparam int CORDIC_STEPS    = 16;
	localparam int ACC_FRAC        = 16;
	localparam int TABLE_LEN       = 24;
	localparam int ISQ_STEPS       = 16;
	localparam int SQW             = 2 * ISQ_STEPS;
	localparam int ISQ_TOP         = 2 * ISQ_STEPS - 2;
	localparam int CW              = 40;
	localparam int ZW              = 32;
	localparam int FIFO_DEPTH      = 4;
	localparam int FPW             = $clog2(FIFO_DEPTH);

	localparam logic [7:0] ID_EXPECTED = 8'hE5;
	localparam logic [7:0] RANGE_MASK  = 8'h03;
	localparam int         FULL_RES_BIT = 3;

	localparam logic signed [ZW-1:0] ATAN_TAB [TABLE_LEN] = '{
		32'sd2949120, 32'sd1740967, 32'sd919879, 32'sd466945,
		32'sd234379, 32'sd117304, 32'sd58666, 32'sd29335,
		32'sd14668, 32'sd7334, 32'sd3667, 32'sd1833,
		32'sd917, 32'sd458, 32'sd229, 32'sd115,
		32'sd57, 32'sd29, 32'sd14, 32'sd7,
		32'sd4, 32'sd2, 32'sd1, 32'sd0
	};

	typedef struct packed {
		logic [7:0] device_id;
		logic [7:0] format_byte;
		logic [7:0] x_low;
		logic [7:0] x_high;
		logic [7:0] y_low;
		logic [7:0] y_high;
		logic [7:0] z_low;
		logic [7:0] z_high;
	} in_item_t;

	typedef struct packed {
		logic               id_ok;
		logic signed [15:0] pitch_deg;
		logic signed [15:0] roll_deg;
		logic [1:0]         range_code;
		logic               hi_res;
	} out_item_t;

	typedef struct packed {
		logic       ok;
		logic [1:0] range_code;
		logic       hi_res;
	} meta_t;

	typedef struct packed {
		meta_t              meta;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
	} q_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef struct packed {
		logic signed [15:0] num;
		logic [SQW-1:0]     rem;
		logic [SQW-1:0]     res;
	} isq_t;

	typedef struct packed {
		meta_t meta;
		isq_t  p;
		isq_t  r;
	} isq_stage_t;

	typedef struct packed {
		logic               nz;
		logic               nneg;
		logic               dz;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
	} cor_t;

	typedef struct packed {
		meta_t meta;
		cor_t  p;
		cor_t  r;
	} cor_stage_t;

	function automatic isq_t isq_step(isq_t a, int k);
		isq_t            o;
		logic [SQW-1:0]  b;
		logic [SQW:0]    t;
		o = a;
		b = SQW'(1) << (ISQ_TOP - 2 * k);
		t = {1'b0, a.res} + {1'b0, b};
		if ({1'b0, a.rem} >= t) begin
			o.rem = a.rem - t[SQW-1:0];
			o.res = (a.res >> 1) + b;
		end else begin
			o.res = a.res >> 1;
		end
		return o;
	endfunction

	function automatic cor_t cor_init(isq_t a);
		cor_t o;
		o.nz   = (a.num == 16'sd0);
		o.nneg = a.num[15];
		o.dz   = (a.res == '0);
		o.x    = CW'(a.res) << ACC_FRAC;
		o.y    = CW'(a.num) <<< ACC_FRAC;
		o.z    = '0;
		return o;
	endfunction

	function automatic cor_t cor_step(cor_t c, int i);
		cor_t o;
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		o  = c;
		dx = c.y >>> i;
		dy = c.x >>> i;
		if (!c.y[CW-1]) begin
			o.x = c.x + dx;
			o.y = c.y - dy;
			o.z = c.z + ATAN_TAB[i];
		end else begin
			o.x = c.x - dx;
			o.y = c.y + dy;
			o.z = c.z - ATAN_TAB[i];
		end
		return o;
	endfunction

	function automatic logic signed [15:0] sat16(logic signed [ZW-1:0] v);
		if (v > 32'sd32767)
			return 16'sh7fff;
		if (v < -32'sd32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic logic signed [15:0] ang_fin(cor_t c);
		logic signed [ZW-1:0] full;
		logic signed [ZW-1:0] zr;
		full = ZW'(90) <<< ANGLE_FRAC_BITS;
		zr   = c.z + (ZW'(1) <<< (ACC_FRAC - ANGLE_FRAC_BITS - 1));
		if (c.nz)
			return 16'sd0;
		if (c.dz)
			return sat16(c.nneg ? -full : full);
		return sat16(zr >>> (ACC_FRAC - ANGLE_FRAC_BITS));
	endfunction

endpackage

// ===== src/acctilt_front.sv =====
`timescale 1ns / 1ps
module acctilt_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   snap_valid,
	output logic                   snap_stall,
	input  acctilt_pkg::in_item_t  snap,
	input  acctilt_pkg::fifo_stat_t qstat,
	output logic                   push,
	output acctilt_pkg::q_item_t   item
);
	import acctilt_pkg::*;

	logic    v_s1;
	logic    acc;
	q_item_t cls;

	assign snap_stall = v_s1 && qstat.full;
	assign acc        = snap_valid && !snap_stall;
	assign push       = v_s1 && !qstat.full;

	always_comb begin
		cls.meta.ok         = (snap.device_id == ID_EXPECTED);
		cls.meta.range_code = 2'(snap.format_byte & RANGE_MASK);
		cls.meta.hi_res     = snap.format_byte[FULL_RES_BIT];
		cls.ax              = {snap.x_high, snap.x_low};
		cls.ay              = {snap.y_high, snap.y_low};
		cls.az              = {snap.z_high, snap.z_low};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			item <= cls;
		end
	end

endmodule

// ===== src/acctilt_fifo.sv =====
`timescale 1ns / 1ps
`include "accelerometer_tilt_angles_defines.svh"
module acctilt_fifo (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  acctilt_pkg::q_item_t    din,
	input  logic                    pop,
	output acctilt_pkg::q_item_t    dout,
	output acctilt_pkg::fifo_stat_t stat
);
	import acctilt_pkg::*;

	q_item_t      mem [FIFO_DEPTH];
	logic [FPW-1:0] wr_q;
	logic [FPW-1:0] rd_q;
	logic [FPW:0]   cnt_q;

	assign dout       = mem[rd_q];
	assign stat.full  = (cnt_q == (FPW + 1)'(FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_q] <= din;
	end

	`ACT_NEVER(a_fifo_overflow, push && stat.full)
	`ACT_NEVER(a_fifo_underflow, pop && stat.empty)
	`ACT_ASSERT(a_fifo_fill, push && !pop |=> !stat.empty)

endmodule

// ===== src/acctilt_back.sv =====
`timescale 1ns / 1ps
module acctilt_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  acctilt_pkg::q_item_t    head,
	input  acctilt_pkg::fifo_stat_t qstat,
	output logic                    pop,
	output logic                    angle_valid,
	input  logic                    angle_stall,
	output acctilt_pkg::out_item_t  angle
);
	import acctilt_pkg::*;

	logic               adv;
	logic               v_s1;
	meta_t              meta_s1;
	logic signed [15:0] ax_s1;
	logic signed [15:0] ay_s1;
	logic [SQW-1:0]     ax2_s1;
	logic [SQW-1:0]     ay2_s1;
	logic [SQW-1:0]     az2_s1;
	logic               isq_v  [ISQ_STEPS+1];
	isq_stage_t         isq_s2 [ISQ_STEPS+1];
	logic               cor_v  [CORDIC_STEPS+1];
	cor_stage_t         cor_s3 [CORDIC_STEPS+1];
	logic signed [15:0] pitch_q;
	logic signed [15:0] roll_q;
	logic [1:0]         range_q;
	logic               fres_q;
	logic signed [15:0] pitch_c;
	logic signed [15:0] roll_c;
	out_item_t          res_c;

	assign adv = !angle_valid || !angle_stall;
	assign pop = adv && !qstat.empty;

	always_comb begin
		pitch_c = ang_fin(cor_s3[CORDIC_STEPS].p);
		roll_c  = ang_fin(cor_s3[CORDIC_STEPS].r);
		res_c.id_ok = cor_s3[CORDIC_STEPS].meta.ok;
		if (cor_s3[CORDIC_STEPS].meta.ok) begin
			res_c.pitch_deg  = pitch_c;
			res_c.roll_deg   = roll_c;
			res_c.range_code = cor_s3[CORDIC_STEPS].meta.range_code;
			res_c.hi_res     = cor_s3[CORDIC_STEPS].meta.hi_res;
		end else begin
			res_c.pitch_deg  = pitch_q;
			res_c.roll_deg   = roll_q;
			res_c.range_code = range_q;
			res_c.hi_res     = fres_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			angle_valid <= 1'b0;
			for (int k = 0; k <= ISQ_STEPS; k++)
				isq_v[k] <= 1'b0;
			for (int i = 0; i <= CORDIC_STEPS; i++)
				cor_v[i] <= 1'b0;
			pitch_q <= '0;
			roll_q  <= '0;
			range_q <= 2'd3;
			fres_q  <= 1'b1;
		end else if (adv) begin
			v_s1     <= pop;
			isq_v[0] <= v_s1;
			for (int k = 0; k < ISQ_STEPS; k++)
				isq_v[k+1] <= isq_v[k];
			cor_v[0] <= isq_v[ISQ_STEPS];
			for (int i = 0; i < CORDIC_STEPS; i++)
				cor_v[i+1] <= cor_v[i];
			angle_valid <= cor_v[CORDIC_STEPS];
			if (cor_v[CORDIC_STEPS] && cor_s3[CORDIC_STEPS].meta.ok) begin
				pitch_q <= pitch_c;
				roll_q  <= roll_c;
				range_q <= cor_s3[CORDIC_STEPS].meta.range_code;
				fres_q  <= cor_s3[CORDIC_STEPS].meta.hi_res;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1 <= head.meta;
			ax_s1   <= head.ax;
			ay_s1   <= head.ay;
			ax2_s1  <= $unsigned(SQW'(head.ax) * SQW'(head.ax));
			ay2_s1  <= $unsigned(SQW'(head.ay) * SQW'(head.ay));
			az2_s1  <= $unsigned(SQW'(head.az) * SQW'(head.az));

			isq_s2[0].meta  <= meta_s1;
			isq_s2[0].p.num <= ax_s1;
			isq_s2[0].p.rem <= ay2_s1 + az2_s1;
			isq_s2[0].p.res <= '0;
			isq_s2[0].r.num <= ay_s1;
			isq_s2[0].r.rem <= ax2_s1 + az2_s1;
			isq_s2[0].r.res <= '0;
			for (int k = 0; k < ISQ_STEPS; k++) begin
				isq_s2[k+1].meta <= isq_s2[k].meta;
				isq_s2[k+1].p    <= isq_step(isq_s2[k].p, k);
				isq_s2[k+1].r    <= isq_step(isq_s2[k].r, k);
			end

			cor_s3[0].meta <= isq_s2[ISQ_STEPS].meta;
			cor_s3[0].p    <= cor_init(isq_s2[ISQ_STEPS].p);
			cor_s3[0].r    <= cor_init(isq_s2[ISQ_STEPS].r);
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				cor_s3[i+1].meta <= cor_s3[i].meta;
				cor_s3[i+1].p    <= cor_step(cor_s3[i].p, i);
				cor_s3[i+1].r    <= cor_step(cor_s3[i].r, i);
			end

			angle <= res_c;
		end
	end

endmodule

// ===== src/accelerometer_tilt_angles.sv =====
`timescale 1ns / 1ps
// Pitch and roll from one accelerometer register snapshot per item. An item
// is taken every cycle when the result side keeps up; each result passes
// through one front register, one queue slot, the squaring register, the
// square-root load, 16 square-root steps, the CORDIC load, 16 CORDIC stages
// and the result register. A stall on the result side freezes the whole
// angle pipeline; the four-entry queue keeps taking items until it is full.
// Snapshots whose ID byte is wrong return id_ok low and the last good angles.
module accelerometer_tilt_angles (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   snap_valid,
	output logic                   snap_stall,
	input  acctilt_pkg::in_item_t  snap,
	output logic                   angle_valid,
	input  logic                   angle_stall,
	output acctilt_pkg::out_item_t angle
);
	import acctilt_pkg::*;

	fifo_stat_t qstat;
	logic       push;
	logic       pop;
	q_item_t    q_in;
	q_item_t    q_head;

	acctilt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap_valid (snap_valid),
		.snap_stall (snap_stall),
		.snap       (snap),
		.qstat      (qstat),
		.push       (push),
		.item       (q_in)
	);

	acctilt_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (q_in),
		.pop    (pop),
		.dout   (q_head),
		.stat   (qstat)
	);

	acctilt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_head),
		.qstat       (qstat),
		.pop         (pop),
		.angle_valid (angle_valid),
		.angle_stall (angle_stall),
		.angle       (angle)
	);

endmodule
